// ===== sv/wss_pkg.sv =====
package wss_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned OFF_W        = 32;
  localparam int unsigned NLEN_W       = 5;
  localparam int unsigned NEEDLE_BYTES = 16;
  localparam int unsigned NIDX_W       = 4;
  localparam int unsigned CFG_W        = 64;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_SENSITIVE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_BACKWARD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET    = 3'd5;

  // One step of the stream as handed from the window to the match tracker.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             eof;
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] stop;
  } wss_step_t;

  typedef struct packed {
    logic             vld;
    logic [OFF_W-1:0] off;
  } wss_match_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic case_sens);
    logic [BYTE_W-1:0] r;
    r = b;
    if (!case_sens && (b inside {[8'h41:8'h5A]})) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== sv/wss_in_if.sv =====
interface wss_in_if import wss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_valid;
  logic              end_of_file;

  modport source (output valid, data_byte, byte_valid, end_of_file, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_file, output ready);
endinterface

// ===== sv/wss_out_if.sv =====
interface wss_out_if import wss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [OFF_W-1:0] match_offset;
  logic             wrapped;

  modport source (output valid, found, match_offset, wrapped, input ready);
  modport sink (input valid, found, match_offset, wrapped, output ready);
endinterface

// ===== sv/wrapping_substring_search.sv =====
// Streaming substring search with wrap-around.
// The input channel carries one file byte per transaction from offset zero
// upward; byte_valid low marks an empty item, end_of_file marks the last
// item of a file. After that item one result transaction appears on the
// output channel: found, the start offset of the reported match, and
// whether it came from the wrapped range. State is then cleared for the
// next file. Needle, length, case folding, direction and start offset are
// written through the configuration port between transactions.
// One input transaction is taken every cycle while ready is high. A byte
// shifts into a row of MAX_NEEDLE window cells, each comparing its byte
// with the needle in the same cycle; the hit is registered and the match
// tracker then commits it, and an end-of-file step loads the output
// register. The output register holds a result until it is taken; while
// it waits, input is still accepted until a second end-of-file
// transaction reaches the tracker, which then holds ready low.
// Reset clears the window, the byte count, the match registers and the
// configuration (case_sensitive resets to one, all else to zero).
module wrapping_substring_search import wss_pkg::*; #(
  parameter int unsigned MAX_NEEDLE = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  wss_in_if.sink               in_s,
  wss_out_if.source            out_s
);

  localparam logic [NLEN_W-1:0] MaxLen = NLEN_W'(MAX_NEEDLE);

  logic [CFG_W-1:0]  needle_low_q, needle_high_q;
  logic [NLEN_W-1:0] needle_length_q;
  logic              case_sensitive_q, search_backward_q;
  logic [OFF_W-1:0]  start_offset_q;

  logic [OFF_W-1:0]  pos_q, pos_d, pos_new;
  logic [NLEN_W-1:0] eff_len;
  logic              accept, take, clear, stall, hit;
  logic [BYTE_W-1:0] folded;
  logic [2*CFG_W-1:0] needle_all;
  wss_step_t         s1_q, s1_d;

  logic [BYTE_W-1:0]     cell_in  [MAX_NEEDLE];
  logic [BYTE_W-1:0]     cell_out [MAX_NEEDLE];
  logic [BYTE_W-1:0]     cell_ndl [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] cell_act, cell_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_low_q      <= '0;
      needle_high_q     <= '0;
      needle_length_q   <= '0;
      case_sensitive_q  <= 1'b1;
      search_backward_q <= 1'b0;
      start_offset_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEEDLE_LOW:      needle_low_q      <= cfg_data_i;
        CFG_NEEDLE_HIGH:     needle_high_q     <= cfg_data_i;
        CFG_NEEDLE_LENGTH:   needle_length_q   <= cfg_data_i[NLEN_W-1:0];
        CFG_CASE_SENSITIVE:  case_sensitive_q  <= cfg_data_i[0];
        CFG_SEARCH_BACKWARD: search_backward_q <= cfg_data_i[0];
        CFG_START_OFFSET:    start_offset_q    <= cfg_data_i[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len    = (needle_length_q > MaxLen) ? MaxLen : needle_length_q;
  assign needle_all = {needle_high_q, needle_low_q};

  assign in_s.ready = !stall;
  assign accept     = in_s.valid && !stall;
  // The byte count saturates; bytes beyond it are dropped.
  assign take       = accept && in_s.byte_valid && (pos_q != '1);
  assign clear      = accept && in_s.end_of_file;
  assign pos_new    = pos_q + OFF_W'(1);
  assign folded     = fold_byte(in_s.data_byte, case_sensitive_q);

  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
    logic [NLEN_W-1:0] rel;
    logic [NIDX_W-1:0] nidx;

    // Window cell j holds the byte that the needle byte at eff_len-1-j must match.
    assign rel         = eff_len - NLEN_W'(j) - NLEN_W'(1);
    assign nidx        = rel[NIDX_W-1:0];
    assign cell_act[j] = NLEN_W'(j) < eff_len;
    assign cell_ndl[j] = fold_byte(needle_all[nidx*BYTE_W +: BYTE_W], case_sensitive_q);

    if (j == 0) begin : g_head
      assign cell_in[j] = folded;
    end else begin : g_body
      assign cell_in[j] = cell_out[j-1];
    end

    wss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (take),
      .clear_i  (clear),
      .active_i (cell_act[j]),
      .byte_i   (cell_in[j]),
      .needle_i (cell_ndl[j]),
      .byte_o   (cell_out[j]),
      .match_o  (cell_match[j])
    );
  end

  assign hit = take && (eff_len != '0) && (pos_new >= OFF_W'(eff_len)) && (&cell_match);

  always_comb begin
    pos_d = pos_q;
    if (clear) begin
      pos_d = '0;
    end else if (take) begin
      pos_d = pos_new;
    end
  end

  always_comb begin
    s1_d       = s1_q;
    s1_d.valid = accept;
    if (accept) begin
      s1_d.hit   = hit;
      s1_d.eof   = in_s.end_of_file;
      s1_d.start = pos_new - OFF_W'(eff_len);
      s1_d.stop  = pos_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      s1_q  <= '0;
    end else if (!stall) begin
      pos_q <= pos_d;
      s1_q  <= s1_d;
    end
  end

  wss_tracker u_tracker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (s1_q),
    .start_offset_i    (start_offset_q),
    .search_backward_i (search_backward_q),
    .stall_o           (stall),
    .out_s             (out_s)
  );

endmodule

// ===== sv/wss_cell.sv =====
module wss_cell import wss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic              clear_i,
  input  logic              active_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [BYTE_W-1:0] needle_i,
  output logic [BYTE_W-1:0] byte_o,
  output logic              match_o
);

  logic [BYTE_W-1:0] byte_q, byte_d;

  // The compare looks at the byte entering this cell, i.e. the window after the shift.
  assign match_o = !active_i || (byte_i == needle_i);
  assign byte_o  = byte_q;

  always_comb begin
    byte_d = byte_q;
    if (clear_i) begin
      byte_d = '0;
    end else if (shift_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

// ===== sv/wss_tracker.sv =====
module wss_tracker import wss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wss_step_t        step_i,
  input  logic [OFF_W-1:0] start_offset_i,
  input  logic             search_backward_i,
  output logic             stall_o,
  wss_out_if.source        out_s
);

  wss_match_t ffs_q, ffs_d;  // first from start
  wss_match_t fbs_q, fbs_d;  // first before start
  wss_match_t lbs_q, lbs_d;  // last before start
  wss_match_t lfs_q, lfs_d;  // last from start
  wss_match_t pri, sec;

  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [OFF_W-1:0] offset_q, offset_d;
  logic             wrapped_q, wrapped_d;
  logic             commit, in_from, in_before;

  // An end-of-file step may only retire when the output register is free or is being read out by the sink.
  assign stall_o = step_i.valid && step_i.eof && out_valid_q && !out_s.ready;
  assign commit  = step_i.valid && !stall_o;

  assign in_from   = step_i.hit && (step_i.start >= start_offset_i);
  assign in_before = step_i.hit && (step_i.stop <= start_offset_i);

  always_comb begin
    ffs_d = ffs_q;
    fbs_d = fbs_q;
    lbs_d = lbs_q;
    lfs_d = lfs_q;
    if (commit && in_from) begin
      if (!ffs_q.vld) begin
        ffs_d = '{vld: 1'b1, off: step_i.start};
      end
      lfs_d = '{vld: 1'b1, off: step_i.start};
    end
    if (commit && in_before) begin
      if (!fbs_q.vld) begin
        fbs_d = '{vld: 1'b1, off: step_i.start};
      end
      lbs_d = '{vld: 1'b1, off: step_i.start};
    end

    if (search_backward_i) begin
      pri = lbs_d;
      sec = lfs_d;
    end else begin
      pri = ffs_d;
      sec = fbs_d;
    end

    out_valid_d = out_valid_q && !out_s.ready;
    found_d     = found_q;
    offset_d    = offset_q;
    wrapped_d   = wrapped_q;
    if (commit && step_i.eof) begin
      out_valid_d = 1'b1;
      if (pri.vld) begin
        found_d   = 1'b1;
        offset_d  = pri.off;
        wrapped_d = 1'b0;
      end else if (sec.vld) begin
        found_d   = 1'b1;
        offset_d  = sec.off;
        wrapped_d = 1'b1;
      end else begin
        found_d   = 1'b0;
        offset_d  = '0;
        wrapped_d = 1'b0;
      end
      ffs_d = '0;
      fbs_d = '0;
      lbs_d = '0;
      lfs_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ffs_q       <= '0;
      fbs_q       <= '0;
      lbs_q       <= '0;
      lfs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ffs_q       <= ffs_d;
      fbs_q       <= fbs_d;
      lbs_q       <= lbs_d;
      lfs_q       <= lfs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q   <= found_d;
    offset_q  <= offset_d;
    wrapped_q <= wrapped_d;
  end

  assign out_s.valid        = out_valid_q;
  assign out_s.found        = found_q;
  assign out_s.match_offset = offset_q;
  assign out_s.wrapped      = wrapped_q;

endmodule
